/* hdl/bdq_pkg.sv */
// Shared command codes, status codes and field widths for the bounded deque.
package bdq_pkg;

  // Fixed field widths of the command and result words
  localparam int MODE_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // Command codes
  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_ERASE      = 3'd4;
  localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd5;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

endpackage

/* hdl/bounded_deque_with_erase.sv */
// Top level: bounded double-ended queue with erase by value over a ring buffer.
//
// Usage: drive mode_i and value_i and raise start; the command is taken at a
// rising edge where start is high and busy is low. Each command yields one
// result word on out_value_o, status_o and count_o, valid for exactly one
// cycle while done_o is high. The receiver cannot stall; results are never
// held back.
//
// Push front, push back, clear and the unused codes answer in the cycle after
// acceptance and leave busy low, so one may follow each cycle. Pops pass
// through state S_POP to wait for the registered read of the entry memory.
// An erase scans the entries from the front one per cycle and then moves the
// later entries one place toward the front, one per cycle through the same
// memory port, holding busy until it is done. Failed pops and erases on an
// empty queue answer in the cycle after acceptance and leave busy low.
//
// Reset clears the fill count, the ring head and the strobe; entry contents
// are undefined until written and are never read before that.
module bounded_deque_with_erase #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [bdq_pkg::MODE_W-1:0]    mode_i,
  input  logic [bdq_pkg::VALUE_W-1:0]   value_i,
  output logic                          done_o,
  output logic [bdq_pkg::VALUE_W-1:0]   out_value_o,
  output logic [bdq_pkg::STATUS_W-1:0]  status_o,
  output logic [bdq_pkg::COUNT_W-1:0]   count_o
);
  import bdq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int PW = AW + 1;
  localparam logic [PW-1:0] DEPTH_P = PW'(DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_SCAN,
    S_SHIFT
  } state_e;

  state_e                  state_q;
  logic [AW-1:0]           head_q;
  logic [PW-1:0]           count_q;
  logic [PW-1:0]           pos_q;
  logic                    front_q;
  logic [DATA_WIDTH-1:0]   word_q;
  logic                    done_q;
  logic [VALUE_W-1:0]      out_value_q;
  logic [STATUS_W-1:0]     status_q;
  logic [COUNT_W-1:0]      count_out_q;

  logic                    accept;
  logic                    full;
  logic                    empty;
  logic [DATA_WIDTH-1:0]   word;
  logic [AW-1:0]           head_dec;
  logic [AW-1:0]           head_inc;

  logic                    ram_we;
  logic [PW-1:0]           wr_off;
  logic [AW-1:0]           ram_waddr;
  logic [DATA_WIDTH-1:0]   ram_wdata;
  logic                    ram_re;
  logic [PW-1:0]           rd_off;
  logic [AW-1:0]           ram_raddr;
  logic [DATA_WIDTH-1:0]   ram_rdata;

  // Map a logical position to a ring address
  function automatic logic [AW-1:0] ring_addr(logic [AW-1:0] base, logic [PW-1:0] off);
    logic [PW:0] sum;
    sum = (PW+1)'(base) + (PW+1)'(off);
    if (sum >= (PW+1)'(DEPTH)) begin
      sum = sum - (PW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign accept   = start && !busy;
  assign busy     = (state_q != S_IDLE);
  assign full     = (count_q == DEPTH_P);
  assign empty    = (count_q == '0);
  assign word     = DATA_WIDTH'(value_i);
  assign head_dec = (head_q == '0) ? LAST_A : head_q - AW'(1);
  assign head_inc = (head_q == LAST_A) ? '0 : head_q + AW'(1);

  // Drive the memory ports from the command or the running sweep
  always_comb begin
    ram_we    = 1'b0;
    wr_off    = '0;
    ram_wdata = word;
    ram_re    = 1'b0;
    rd_off    = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (mode_i)
            MODE_PUSH_FRONT: ram_we = !full;
            MODE_PUSH_BACK: begin
              ram_we = !full;
              wr_off = count_q;
            end
            MODE_POP_FRONT: ram_re = !empty;
            MODE_POP_BACK: begin
              ram_re = !empty;
              rd_off = count_q - PW'(1);
            end
            MODE_ERASE: ram_re = !empty;
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        ram_re = (pos_q + PW'(1) < count_q);
        rd_off = pos_q + PW'(1);
      end
      S_SHIFT: begin
        ram_we    = 1'b1;
        wr_off    = pos_q;
        ram_wdata = ram_rdata;
        ram_re    = (pos_q + PW'(2) < count_q);
        rd_off    = pos_q + PW'(2);
      end
      default: ;
    endcase
  end

  // Push front writes below the head; every other access is head relative
  assign ram_waddr = (state_q == S_IDLE && mode_i == MODE_PUSH_FRONT) ? head_dec
                                                                     : ring_addr(head_q, wr_off);
  assign ram_raddr = ring_addr(head_q, rd_off);

  // Hold state, pointers and the result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      pos_q       <= '0;
      front_q     <= 1'b0;
      word_q      <= '0;
      done_q      <= 1'b0;
      out_value_q <= '0;
      status_q    <= ST_OK;
      count_out_q <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            done_q      <= 1'b1;
            out_value_q <= '0;
            status_q    <= ST_OK;
            count_out_q <= COUNT_W'(count_q);
            case (mode_i)
              MODE_PUSH_FRONT: begin
                if (full) begin
                  status_q <= ST_FULL;
                end else begin
                  head_q      <= head_dec;
                  count_q     <= count_q + PW'(1);
                  count_out_q <= COUNT_W'(count_q + PW'(1));
                end
              end
              MODE_PUSH_BACK: begin
                if (full) begin
                  status_q <= ST_FULL;
                end else begin
                  count_q     <= count_q + PW'(1);
                  count_out_q <= COUNT_W'(count_q + PW'(1));
                end
              end
              MODE_POP_FRONT, MODE_POP_BACK: begin
                if (empty) begin
                  status_q <= ST_EMPTY;
                end else begin
                  done_q  <= 1'b0;
                  front_q <= (mode_i == MODE_POP_FRONT);
                  state_q <= S_POP;
                end
              end
              MODE_ERASE: begin
                if (empty) begin
                  status_q <= ST_NOTFOUND;
                end else begin
                  done_q  <= 1'b0;
                  pos_q   <= '0;
                  word_q  <= word;
                  state_q <= S_SCAN;
                end
              end
              MODE_CLEAR: begin
                count_q     <= '0;
                count_out_q <= '0;
              end
              default: ;
            endcase
          end
        end
        S_POP: begin
          done_q      <= 1'b1;
          out_value_q <= VALUE_W'(ram_rdata);
          status_q    <= ST_OK;
          count_q     <= count_q - PW'(1);
          count_out_q <= COUNT_W'(count_q - PW'(1));
          if (front_q) begin
            head_q <= head_inc;
          end
          state_q <= S_IDLE;
        end
        S_SCAN: begin
          if (ram_rdata == word_q) begin
            if (pos_q + PW'(1) == count_q) begin
              // Match on the last entry: nothing to close up
              done_q      <= 1'b1;
              status_q    <= ST_OK;
              count_q     <= count_q - PW'(1);
              count_out_q <= COUNT_W'(count_q - PW'(1));
              state_q     <= S_IDLE;
            end else begin
              state_q <= S_SHIFT;
            end
          end else if (pos_q + PW'(1) == count_q) begin
            done_q      <= 1'b1;
            status_q    <= ST_NOTFOUND;
            count_out_q <= COUNT_W'(count_q);
            state_q     <= S_IDLE;
          end else begin
            pos_q <= pos_q + PW'(1);
          end
        end
        S_SHIFT: begin
          // Advance the gap one place toward the back
          pos_q <= pos_q + PW'(1);
          if (pos_q + PW'(2) == count_q) begin
            done_q      <= 1'b1;
            status_q    <= ST_OK;
            count_q     <= count_q - PW'(1);
            count_out_q <= COUNT_W'(count_q - PW'(1));
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  bdq_ram #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign done_o      = done_q;
  assign out_value_o = out_value_q;
  assign status_o    = status_q;
  assign count_o     = count_out_q;

endmodule

/* hdl/bdq_ram.sv */
// Simple dual-port entry store: one write port, one registered read port.
module bdq_ram #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  parameter int AW         = $clog2(DEPTH)
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AW-1:0]         waddr_i,
  input  logic [DATA_WIDTH-1:0] wdata_i,
  input  logic                  re_i,
  input  logic [AW-1:0]         raddr_i,
  output logic [DATA_WIDTH-1:0] rdata_o
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;

  // Write one word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read one word, data valid the next cycle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/bdq_checker.sv */
// Port-level checks for the bounded deque, bound to the top level.
module bdq_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic [bdq_pkg::MODE_W-1:0]    mode_i,
  input logic                          done_o,
  input logic [bdq_pkg::VALUE_W-1:0]   out_value_o,
  input logic [bdq_pkg::STATUS_W-1:0]  status_o,
  input logic [bdq_pkg::COUNT_W-1:0]   count_o
);
  import bdq_pkg::*;

  // No result word while a long command is still in flight
  a_no_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !done_o)
    else $error("result strobe while busy");

  // Every result traces back to an accepted command or a finishing sweep
  a_done_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(start && !busy) || $past(busy)))
    else $error("result without a command");

  // Push and clear commands answer in the next cycle
  a_push_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (mode_i == MODE_PUSH_FRONT || mode_i == MODE_PUSH_BACK ||
                        mode_i == MODE_CLEAR))
    |=> (done_o && !busy))
    else $error("push or clear did not complete in one cycle");

  // A failed command returns a zero word
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |-> (out_value_o == '0))
    else $error("nonzero word on a failed command");

  // An empty pop reports an empty queue
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_EMPTY) |-> (count_o == '0))
    else $error("empty status with nonzero count");

endmodule

bind bounded_deque_with_erase bdq_checker u_bdq_checker (.*);

/* dv/testbench.sv */
// Self-checking testbench for the bounded deque: directed and random commands vs a shadow deque.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bdq_pkg::*;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int MAX_IDLE   = 12;
  localparam int SETTLE     = 4 * DEPTH;
  localparam int STALL_LIMIT = 1000;
  localparam int RANDOM_WORDS = 1420;

  // Codes the block treats as no operation
  localparam logic [MODE_W-1:0] MODE_SPARE6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE7 = 3'd7;

  typedef struct {
    logic [MODE_W-1:0]  mode;
    logic [VALUE_W-1:0] value;
    int                 idle;
    bit                 drain;
  } command_t;

  typedef struct {
    logic [VALUE_W-1:0]  out_value;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
  } reply_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [MODE_W-1:0]   mode_i = '0;
  logic [VALUE_W-1:0]  value_i = '0;
  logic                done_o;
  logic [VALUE_W-1:0]  out_value_o;
  logic [STATUS_W-1:0] status_o;
  logic [COUNT_W-1:0]  count_o;

  command_t           pending_cmds[$];
  command_t           next_cmd;
  reply_t             awaited_replies[$];
  reply_t             want;
  logic [VALUE_W-1:0] shadow_words[$];
  int                 issued_cnt = 0;
  int                 returned_cnt = 0;
  int                 stall_cycles = 0;
  int                 failures = 0;

  bounded_deque_with_erase #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .mode_i      (mode_i),
    .value_i     (value_i),
    .done_o      (done_o),
    .out_value_o (out_value_o),
    .status_o    (status_o),
    .count_o     (count_o)
  );

  // Free-running clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Apply one command to the shadow deque and return the reply it should give
  function automatic reply_t deque_reply(logic [MODE_W-1:0] mode, logic [VALUE_W-1:0] word);
    reply_t r;
    int     hit;
    r.out_value = '0;
    r.status    = ST_OK;
    hit         = -1;
    case (mode)
      MODE_PUSH_FRONT: begin
        if (shadow_words.size() >= DEPTH) r.status = ST_FULL;
        else shadow_words.insert(0, word);
      end
      MODE_PUSH_BACK: begin
        if (shadow_words.size() >= DEPTH) r.status = ST_FULL;
        else shadow_words.insert(shadow_words.size(), word);
      end
      MODE_POP_FRONT: begin
        if (shadow_words.size() == 0) r.status = ST_EMPTY;
        else begin
          r.out_value = shadow_words[0];
          shadow_words.delete(0);
        end
      end
      MODE_POP_BACK: begin
        if (shadow_words.size() == 0) r.status = ST_EMPTY;
        else begin
          r.out_value = shadow_words[shadow_words.size() - 1];
          shadow_words.delete(shadow_words.size() - 1);
        end
      end
      MODE_ERASE: begin
        for (int i = 0; i < shadow_words.size() && hit < 0; i++)
          if (shadow_words[i] == word) hit = i;
        if (hit < 0) r.status = ST_NOTFOUND;
        else shadow_words.delete(hit);
      end
      MODE_CLEAR: begin
        shadow_words.delete();
      end
      default: ;
    endcase
    r.count = COUNT_W'(shadow_words.size());
    return r;
  endfunction

  task automatic add_cmd(logic [MODE_W-1:0] mode, logic [VALUE_W-1:0] value, int idle,
                         bit drain);
    command_t c;
    c.mode  = mode;
    c.value = value;
    c.idle  = idle;
    c.drain = drain;
    pending_cmds.insert(pending_cmds.size(), c);
  endtask

  // Driver: record each accepted word, then launch the next one after its idle gap
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start      <= 1'b0;
      mode_i     <= '0;
      value_i    <= '0;
      issued_cnt <= 0;
    end else begin
      if (start && !busy) begin
        awaited_replies.insert(awaited_replies.size(), deque_reply(mode_i, value_i));
        issued_cnt <= issued_cnt + 1;
      end
      if (!start || !busy) begin
        if (pending_cmds.size() == 0) begin
          start <= 1'b0;
        end else if (pending_cmds[0].drain &&
                     ((start && !busy) || issued_cnt != returned_cnt)) begin
          // hold off until every reply is back
          start <= 1'b0;
        end else if (pending_cmds[0].idle > 0) begin
          pending_cmds[0].drain = 1'b0;
          pending_cmds[0].idle--;
          start <= 1'b0;
        end else begin
          next_cmd = pending_cmds[0];
          pending_cmds.delete(0);
          start   <= 1'b1;
          mode_i  <= next_cmd.mode;
          value_i <= next_cmd.value;
        end
      end
    end
  end

  // Monitor: compare each reply word with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      returned_cnt <= 0;
    end else if (done_o) begin
      if (returned_cnt == issued_cnt) begin
        $display("%0t: unexpected reply value %h status %0d count %0d", $time,
                 out_value_o, status_o, count_o);
        failures++;
      end else begin
        want = awaited_replies[0];
        awaited_replies.delete(0);
        returned_cnt <= returned_cnt + 1;
        if (out_value_o !== want.out_value) begin
          $display("%0t: out_value expected %h actual %h", $time, want.out_value, out_value_o);
          failures++;
        end
        if (status_o !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
          failures++;
        end
        if (count_o !== want.count) begin
          $display("%0t: count expected %0d actual %0d", $time, want.count, count_o);
          failures++;
        end
      end
    end
  end

  // Watchdog: stop when neither a command nor a reply moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: timeout with %0d replies outstanding", $time, awaited_replies.size());
        $display("FAIL bounded_deque_with_erase");
        $finish;
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    logic [VALUE_W-1:0] pool[8];
    logic [VALUE_W-1:0] back_word;
    logic [VALUE_W-1:0] word;
    logic [MODE_W-1:0]  mode;
    int bias, pace, r, push_pct, pop_pct, erase_pct, idle;

    // Directed: empty cases, fill to full, overflow at both ends, erase cases
    add_cmd(MODE_POP_FRONT, '0, 0, 1'b0);
    add_cmd(MODE_POP_BACK, 32'hFFFF_FFFF, 1, 1'b0);
    add_cmd(MODE_ERASE, '0, 0, 1'b0);
    add_cmd(MODE_SPARE7, $urandom, 2, 1'b0);
    back_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      case (i)
        0:       word = '0;
        1:       word = 32'hFFFF_FFFF;
        2, 9:    word = 32'hA5A5_A5A5;
        default: word = $urandom;
      endcase
      if (i % 2 == 0) begin
        add_cmd(MODE_PUSH_BACK, word, $urandom_range(0, 3), 1'b0);
        back_word = word;
      end else begin
        add_cmd(MODE_PUSH_FRONT, word, $urandom_range(0, 3), 1'b0);
      end
    end
    add_cmd(MODE_PUSH_FRONT, 32'h1234_5678, 0, 1'b0);
    add_cmd(MODE_PUSH_BACK, 32'h8765_4321, 0, 1'b0);
    add_cmd(MODE_ERASE, back_word, 0, 1'b0);
    add_cmd(MODE_ERASE, 32'hA5A5_A5A5, 1, 1'b0);
    add_cmd(MODE_ERASE, 32'h0BAD_F00D, 0, 1'b0);
    add_cmd(MODE_POP_FRONT, '0, 0, 1'b0);
    add_cmd(MODE_POP_BACK, '0, 2, 1'b0);
    add_cmd(MODE_SPARE6, $urandom, 0, 1'b0);
    add_cmd(MODE_CLEAR, '0, 0, 1'b0);

    // Random: segments that lean toward filling, draining or neither
    foreach (pool[k]) pool[k] = $urandom;
    bias = 0;
    pace = 0;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 40 == 0) begin
        bias = $urandom_range(0, 2);
        pace = $urandom_range(0, 2);
        pool[$urandom_range(0, 7)] = $urandom;
      end
      case (bias)
        0:       begin push_pct = 60; pop_pct = 20; erase_pct = 16; end
        1:       begin push_pct = 25; pop_pct = 45; erase_pct = 26; end
        default: begin push_pct = 40; pop_pct = 30; erase_pct = 26; end
      endcase
      r = $urandom_range(0, 99);
      if (r < push_pct)
        mode = $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
      else if (r < push_pct + pop_pct)
        mode = $urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_BACK;
      else if (r < push_pct + pop_pct + erase_pct)
        mode = MODE_ERASE;
      else if (r < 98)
        mode = MODE_CLEAR;
      else
        mode = (r == 98) ? MODE_SPARE6 : MODE_SPARE7;
      word = ($urandom_range(0, 9) < 7) ? pool[$urandom_range(0, 7)] : $urandom;
      case (pace)
        0:       idle = 0;
        1:       idle = $urandom_range(0, MAX_IDLE);
        default: idle = ($urandom_range(0, 5) == 0) ? $urandom_range(0, MAX_IDLE) : 0;
      endcase
      add_cmd(mode, word, idle, n == 0 || $urandom_range(0, 99) == 0);
    end

    // Release reset away from the active edge
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Drain: wait for every word to be taken and answered, then settle
    while (pending_cmds.size() != 0 || start || issued_cnt != returned_cnt)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (awaited_replies.size() != 0) begin
      $display("%0t: %0d replies never arrived", $time, awaited_replies.size());
      failures++;
    end
    if (failures == 0) begin
      $display("PASS bounded_deque_with_erase");
    end else begin
      $display("FAIL bounded_deque_with_erase");
    end
    $finish;
  end

endmodule
